@@ sv/assert_macros.svh @@
// Assertion macros shared by the baseline remover RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while arst_n is low.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be true on a rising clk edge.
`define ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ sv/mmbr_pkg.sv @@
// Shared constants and types of the moving mean baseline remover.
package mmbr_pkg;

	// Window and channel geometry
	localparam int WINDOW       = 256;
	localparam int MAX_CHANNELS = 1024;
	localparam int SAMPLE_BITS  = 24;

	// Fixed field widths
	localparam int CHAN_W = 10;
	localparam int CFG_W  = 11;
	localparam int OUT_W  = 25;
	localparam int SUM_W  = 32;

	// Derived storage geometry
	localparam int SLOT_W     = $clog2(WINDOW);
	localparam int CH_BITS    = $clog2(MAX_CHANNELS);
	localparam int RING_AW    = SLOT_W + CH_BITS;
	localparam int RING_DEPTH = 2 ** RING_AW;

	// Mean divisor and its reciprocal: q = (|sum| * RECIP_M) >> RECIP_SHIFT,
	// off by at most one below the true quotient.
	localparam int DIV         = WINDOW + 1;
	localparam int RECIP_SHIFT = 31 + $clog2(DIV);
	localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(DIV);
	localparam logic [SUM_W-1:0] RECIP_M = RECIP_FULL[SUM_W-1:0];
	localparam int Q_W = 64 - RECIP_SHIFT;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One classified sample request
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [CHAN_W-1:0]             channel;
		logic                          active;
		logic [SLOT_W-1:0]             slot;
		logic                          full;
	} mmbr_item_t;

endpackage

@@ sv/mmbr_if.sv @@
// Sample and result channel interfaces.
interface mmbr_in_if
	import mmbr_pkg::*;
();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [CHAN_W-1:0]             channel;

	modport source (output valid, output sample, output channel, input ready);
	modport sink (input valid, input sample, input channel, output ready);
endinterface

interface mmbr_out_if
	import mmbr_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] corrected;
	logic [CHAN_W-1:0]       out_channel;

	modport source (output valid, output corrected, output out_channel, input ready);
	modport sink (input valid, input corrected, input out_channel, output ready);
endinterface

@@ sv/mmbr_front.sv @@
// Front end: channel count register, request classification, frame slot tracking.
`include "assert_macros.svh"

module mmbr_front
	import mmbr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	mmbr_in_if.sink          src,
	input  logic             init_busy,
	input  logic             q_full,
	output logic             push,
	output mmbr_item_t       push_item
);

	logic [CFG_W-1:0]  num_ch_q;
	logic [CFG_W-1:0]  eff_ch;
	logic [SLOT_W-1:0] slot_q;
	logic              full_q;
	logic              active;
	logic              last;
	logic              advance;

	// Clamp the channel count to 1..MAX_CHANNELS
	always_comb begin
		if (num_ch_q == '0) begin
			eff_ch = CFG_W'(1);
		end else if (num_ch_q > CFG_W'(MAX_CHANNELS)) begin
			eff_ch = CFG_W'(MAX_CHANNELS);
		end else begin
			eff_ch = num_ch_q;
		end
	end

	// Classify the incoming request
	assign active  = CFG_W'(src.channel) < eff_ch;
	assign last    = CFG_W'(src.channel) == (eff_ch - CFG_W'(1));
	assign src.ready = !q_full && !init_busy;
	assign push      = src.valid && src.ready;
	assign advance   = push && active && last;

	always_comb begin
		push_item.sample  = src.sample;
		push_item.channel = src.channel;
		push_item.active  = active;
		push_item.slot    = slot_q;
		push_item.full    = full_q;
	end

	// Config register and frame slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ch_q <= CFG_W'(1);
			slot_q   <= '0;
			full_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_ch_q <= cfg_wdata;
			end
			if (advance) begin
				if (slot_q == SLOT_W'(WINDOW - 1)) begin
					slot_q <= '0;
					full_q <= 1'b1;
				end else begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
		end
	end

	`ASSERT_CLK(a_slot_moves_on_last, !$past(advance) |-> $stable(slot_q), "slot moved without frame end")
	`ASSERT_NEVER(a_push_in_init, push && init_busy, "request accepted during sum clear")

endmodule

@@ sv/mmbr_queue.sv @@
// Short request queue between front and back.
`include "assert_macros.svh"

module mmbr_queue
	import mmbr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mmbr_item_t push_item,
	output logic       full,
	input  logic       pop,
	output mmbr_item_t head,
	output logic       head_vld
);

	mmbr_item_t        entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_pop;

	assign full     = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign head_vld = cnt_q != '0;
	assign head     = entries_q[rd_ptr_q];
	assign do_pop   = pop && head_vld;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

	`ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
	`ASSERT_NEVER(a_cnt_range, cnt_q > (QPTR_W + 1)'(QUEUE_DEPTH), "queue count past depth")

endmodule

@@ sv/mmbr_back.sv @@
// Back end: history ring, per-channel sums, mean division and result register.
`include "assert_macros.svh"

module mmbr_back
	import mmbr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mmbr_item_t head,
	input  logic       head_vld,
	output logic       pop,
	output logic       init_busy,
	mmbr_out_if.source res
);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [CHAN_W-1:0]             channel;
		logic                          active;
	} mmbr_tag_t;

	// Storage
	logic signed [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
	logic signed [SUM_W-1:0]       sum_mem [MAX_CHANNELS];

	// Control
	logic               en;
	logic               init_busy_q;
	logic [CH_BITS-1:0] clr_idx_q;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic               wb_vld_q;

	// Payload
	mmbr_item_t                    item_s1;
	logic signed [SAMPLE_BITS-1:0] ring_rd_s1;
	logic signed [SUM_W-1:0]       sum_rd_s1;
	mmbr_tag_t                     tag_s2, tag_s3, tag_s4;
	logic signed [SUM_W-1:0]       sum_s2;
	logic [SUM_W-1:0]              mag_s3;
	logic                          neg_s3;
	logic [Q_W-1:0]                q0_s3;
	logic signed [OUT_W-1:0]       mean_s4;
	logic [CH_BITS-1:0]            wb_ch_q;
	logic signed [SUM_W-1:0]       wb_sum_q;
	logic signed [OUT_W-1:0]       corrected_q;
	logic [CHAN_W-1:0]             out_chan_q;

	// Combinational
	logic [RING_AW-1:0]      ring_addr;
	logic [CH_BITS-1:0]      ch_s1;
	logic signed [SUM_W-1:0] base_sum;
	logic signed [SUM_W-1:0] old_term;
	logic signed [SUM_W-1:0] new_sum;
	logic                    sum_we;
	logic [CH_BITS-1:0]      sum_waddr;
	logic signed [SUM_W-1:0] sum_wdata;
	logic                    neg_s2;
	logic [SUM_W-1:0]        mag_s2;
	logic [63:0]             prod_s2;
	logic [SUM_W:0]          rem_s3;
	logic [Q_W-1:0]          q_s3;
	logic signed [OUT_W-1:0] x_ext_s4;

	// Whole pipeline moves when the result register is free or drained
	assign en        = !out_vld_q || res.ready;
	assign pop       = en && head_vld;
	assign init_busy = init_busy_q;

	// History ring: old entry read and, for an active channel, new sample written in the pop cycle
	assign ring_addr = {head.slot, CH_BITS'(head.channel)};

	always_ff @(posedge clk) begin
		if (en) begin
			ring_rd_s1 <= ring_mem[ring_addr];
		end
		if (pop && head.active) begin
			ring_mem[ring_addr] <= head.sample;
		end
	end

	// Sum update with bypass of the previous sample's write
	assign ch_s1    = CH_BITS'(item_s1.channel);
	assign base_sum = (wb_vld_q && wb_ch_q == ch_s1) ? wb_sum_q : sum_rd_s1;
	assign old_term = item_s1.full ? SUM_W'(ring_rd_s1) : '0;
	assign new_sum  = base_sum - old_term + SUM_W'(item_s1.sample);

	// Sum memory port: clearing sweep after reset, then pipeline writes
	assign sum_we    = init_busy_q || (en && vld_s1 && item_s1.active);
	assign sum_waddr = init_busy_q ? clr_idx_q : ch_s1;
	assign sum_wdata = init_busy_q ? '0 : new_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_rd_s1 <= sum_mem[CH_BITS'(head.channel)];
		end
		if (sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
	end

	// Magnitude times reciprocal
	assign neg_s2  = sum_s2[SUM_W-1];
	assign mag_s2  = neg_s2 ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);
	assign prod_s2 = 64'(mag_s2) * 64'(RECIP_M);

	// Quotient fix-up: estimate is at most one low
	assign rem_s3 = (SUM_W + 1)'(mag_s3) - (SUM_W + 1)'((SUM_W + 1)'(q0_s3) * (SUM_W + 1)'(DIV));
	assign q_s3   = (rem_s3 >= (SUM_W + 1)'(DIV)) ? q0_s3 + Q_W'(1) : q0_s3;

	assign x_ext_s4 = OUT_W'(tag_s4.sample);

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= head;

			tag_s2.sample  <= item_s1.sample;
			tag_s2.channel <= item_s1.channel;
			tag_s2.active  <= item_s1.active;
			sum_s2         <= new_sum;
			wb_ch_q        <= ch_s1;
			wb_sum_q       <= new_sum;

			tag_s3 <= tag_s2;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			q0_s3  <= prod_s2[63:RECIP_SHIFT];

			tag_s4  <= tag_s3;
			mean_s4 <= neg_s3 ? -OUT_W'(q_s3) : OUT_W'(q_s3);

			corrected_q <= tag_s4.active ? x_ext_s4 - mean_s4 : x_ext_s4;
			out_chan_q  <= tag_s4.channel;
		end
	end

	// Pipeline control, bypass valid and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q <= 1'b1;
			clr_idx_q   <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_vld_q   <= 1'b0;
			wb_vld_q    <= 1'b0;
		end else begin
			if (init_busy_q) begin
				if (clr_idx_q == CH_BITS'(MAX_CHANNELS - 1)) begin
					init_busy_q <= 1'b0;
				end
				clr_idx_q <= clr_idx_q + CH_BITS'(1);
			end
			if (en) begin
				vld_s1    <= pop;
				vld_s2    <= vld_s1;
				vld_s3    <= vld_s2;
				vld_s4    <= vld_s3;
				out_vld_q <= vld_s4;
				wb_vld_q  <= vld_s1 && item_s1.active;
			end
		end
	end

	assign res.valid       = out_vld_q;
	assign res.corrected   = corrected_q;
	assign res.out_channel = out_chan_q;

	`ASSERT_NEVER(a_no_work_in_init, init_busy_q && (pop || vld_s1), "request in flight during sum clear")
	`ASSERT_CLK(a_bypass_after_init, wb_vld_q |-> !init_busy_q, "bypass live during sum clear")

endmodule

@@ sv/moving_mean_baseline_removal_top.sv @@
// Top level of the multichannel moving mean baseline remover.
// Each request carries one signed 24-bit sample and its channel; the result is the
// sample minus its channel's running window sum divided by WINDOW+1 (truncated toward
// zero), with channels at or above the configured count passed through unchanged.
// One sample is taken per clock cycle when the output is not stalled: the per-channel
// sum is read once per sample and rewritten for active channels with a one-entry bypass,
// and the history ring is read, and for active channels written, at the same address in
// the pop cycle. Through an empty queue the result passes the queue entry and then four
// register stages, the last of which loads the result register. After reset the
// 1024-entry sum memory is cleared one entry per cycle, so no sample is accepted until
// the sweep is done; num_channels writes are taken at any time and must only be made
// while the block is idle.
module moving_mean_baseline_removal_top
	import mmbr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	mmbr_in_if.sink          in_ch,
	mmbr_out_if.source       out_ch
);

	logic       init_busy;
	logic       q_full;
	logic       push;
	mmbr_item_t push_item;
	logic       pop;
	mmbr_item_t head;
	logic       head_vld;

	// Accept and classify requests
	mmbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.src       (in_ch),
		.init_busy (init_busy),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue
	mmbr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.head_vld  (head_vld)
	);

	// Storage update and mean removal
	mmbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_vld  (head_vld),
		.pop       (pop),
		.init_busy (init_busy),
		.res       (out_ch)
	);

endmodule
